// File: rtl/core/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none
package rau_pkg;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_SUB = 3'd1;
   localparam logic [2:0] ACT_MUL = 3'd2;
   localparam logic [2:0] ACT_DIV = 3'd3;
   localparam logic [2:0] ACT_CMP = 3'd4;

   localparam int unsigned DIV_STEPS = 64;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH,
      ST_GD_INIT, ST_GD_RUN, ST_VD_INIT, ST_VD_RUN,
      ST_A_M1, ST_A_M2, ST_A_M3, ST_A_M4,
      ST_M_M1, ST_M_M2, ST_M_M3,
      ST_D_M1, ST_D_M2, ST_D_M3,
      ST_C_M1, ST_C_M2, ST_C_M3,
      ST_GR_INIT, ST_GR_RUN, ST_VR_INIT, ST_VR_RUN,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_AN_FA, MUL_BN_FB, MUL_AD_FA,
      MUL_AN_BN, MUL_AD_BD, MUL_AN_BD, MUL_BN_AD
   } mul_sel_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD,
      OP_GCD_DEN, OP_GCD_RED, OP_GCD_STEP, OP_GCD_FIN,
      OP_DIV_DEN, OP_DIV_RED, OP_DIV_STEP, OP_DIV_SAVE,
      OP_ST_TA, OP_ST_SUM, OP_ST_NUM, OP_ST_DEN,
      OP_FIN_RED, OP_FIN_CMP, OP_FIN_CLR, OP_OUT_LOAD,
      OP_MUL_AD_BN
   } op_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type mul;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       b_zero;
      logic       gcd_done;
      logic       div_done;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/core/rau_ctrl.sv
// Sequencing state machine of the rational arithmetic unit.
// Depends on rau_pkg; drives the datapath by command, reads its status.
`default_nettype none
module rau_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rau_pkg::status_type status,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output rau_pkg::cmd_type         cmd
);

   rau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = rau_pkg::ST_DISPATCH;
         end
         rau_pkg::ST_DISPATCH: begin
            case (status.action)
               rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: state_in = rau_pkg::ST_GD_INIT;
               rau_pkg::ACT_MUL: state_in = rau_pkg::ST_M_M1;
               rau_pkg::ACT_DIV: state_in = status.b_zero ? rau_pkg::ST_OUT
                                                          : rau_pkg::ST_D_M1;
               rau_pkg::ACT_CMP: state_in = rau_pkg::ST_C_M1;
               default: state_in = rau_pkg::ST_OUT;
            endcase
         end
         rau_pkg::ST_GD_INIT: state_in = rau_pkg::ST_GD_RUN;
         rau_pkg::ST_GD_RUN:  if (status.gcd_done) state_in = rau_pkg::ST_VD_INIT;
         rau_pkg::ST_VD_INIT: state_in = rau_pkg::ST_VD_RUN;
         rau_pkg::ST_VD_RUN:  if (status.div_done) state_in = rau_pkg::ST_A_M1;
         rau_pkg::ST_A_M1:    state_in = rau_pkg::ST_A_M2;
         rau_pkg::ST_A_M2:    state_in = rau_pkg::ST_A_M3;
         rau_pkg::ST_A_M3:    state_in = rau_pkg::ST_A_M4;
         rau_pkg::ST_A_M4:    state_in = rau_pkg::ST_GR_INIT;
         rau_pkg::ST_M_M1:    state_in = rau_pkg::ST_M_M2;
         rau_pkg::ST_M_M2:    state_in = rau_pkg::ST_M_M3;
         rau_pkg::ST_M_M3:    state_in = rau_pkg::ST_GR_INIT;
         rau_pkg::ST_D_M1:    state_in = rau_pkg::ST_D_M2;
         rau_pkg::ST_D_M2:    state_in = rau_pkg::ST_D_M3;
         rau_pkg::ST_D_M3:    state_in = rau_pkg::ST_GR_INIT;
         rau_pkg::ST_C_M1:    state_in = rau_pkg::ST_C_M2;
         rau_pkg::ST_C_M2:    state_in = rau_pkg::ST_C_M3;
         rau_pkg::ST_C_M3:    state_in = rau_pkg::ST_OUT;
         rau_pkg::ST_GR_INIT: state_in = rau_pkg::ST_GR_RUN;
         rau_pkg::ST_GR_RUN:  if (status.gcd_done) state_in = rau_pkg::ST_VR_INIT;
         rau_pkg::ST_VR_INIT: state_in = rau_pkg::ST_VR_RUN;
         rau_pkg::ST_VR_RUN:  if (status.div_done) state_in = rau_pkg::ST_OUT;
         rau_pkg::ST_OUT:     if (status.out_free) state_in = rau_pkg::ST_IDLE;
         default:             state_in = rau_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = rau_pkg::OP_NONE;
      cmd.mul    = rau_pkg::MUL_NONE;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = rau_pkg::OP_LOAD;
         end
         rau_pkg::ST_DISPATCH: begin
            if (!(status.action == rau_pkg::ACT_ADD || status.action == rau_pkg::ACT_SUB ||
                  status.action == rau_pkg::ACT_MUL || status.action == rau_pkg::ACT_CMP ||
                  (status.action == rau_pkg::ACT_DIV && !status.b_zero)))
               cmd.op = rau_pkg::OP_FIN_CLR;
         end
         rau_pkg::ST_GD_INIT: cmd.op = rau_pkg::OP_GCD_DEN;
         rau_pkg::ST_GD_RUN:
            cmd.op = status.gcd_done ? rau_pkg::OP_GCD_FIN : rau_pkg::OP_GCD_STEP;
         rau_pkg::ST_VD_INIT: cmd.op = rau_pkg::OP_DIV_DEN;
         rau_pkg::ST_VD_RUN:
            cmd.op = status.div_done ? rau_pkg::OP_DIV_SAVE : rau_pkg::OP_DIV_STEP;
         rau_pkg::ST_A_M1: cmd.mul = rau_pkg::MUL_AN_FA;
         rau_pkg::ST_A_M2: begin
            cmd.mul = rau_pkg::MUL_BN_FB;
            cmd.op  = rau_pkg::OP_ST_TA;
         end
         rau_pkg::ST_A_M3: begin
            cmd.mul = rau_pkg::MUL_AD_FA;
            cmd.op  = rau_pkg::OP_ST_SUM;
         end
         rau_pkg::ST_A_M4: cmd.op = rau_pkg::OP_ST_DEN;
         rau_pkg::ST_M_M1: cmd.mul = rau_pkg::MUL_AN_BN;
         rau_pkg::ST_M_M2: begin
            cmd.mul = rau_pkg::MUL_AD_BD;
            cmd.op  = rau_pkg::OP_ST_NUM;
         end
         rau_pkg::ST_M_M3: cmd.op = rau_pkg::OP_ST_DEN;
         rau_pkg::ST_D_M1: cmd.mul = rau_pkg::MUL_AN_BD;
         rau_pkg::ST_D_M2: begin
            cmd.mul = rau_pkg::MUL_BN_AD;
            cmd.op  = rau_pkg::OP_ST_NUM;
         end
         rau_pkg::ST_D_M3: cmd.op = rau_pkg::OP_ST_DEN;
         rau_pkg::ST_C_M1: cmd.mul = rau_pkg::MUL_AN_BD;
         rau_pkg::ST_C_M2: begin
            cmd.mul = rau_pkg::MUL_BN_AD;
            cmd.op  = rau_pkg::OP_ST_TA;
         end
         rau_pkg::ST_C_M3: cmd.op = rau_pkg::OP_FIN_CMP;
         rau_pkg::ST_GR_INIT: cmd.op = rau_pkg::OP_GCD_RED;
         rau_pkg::ST_GR_RUN:
            cmd.op = status.gcd_done ? rau_pkg::OP_GCD_FIN : rau_pkg::OP_GCD_STEP;
         rau_pkg::ST_VR_INIT: cmd.op = rau_pkg::OP_DIV_RED;
         rau_pkg::ST_VR_RUN:
            cmd.op = status.div_done ? rau_pkg::OP_FIN_RED : rau_pkg::OP_DIV_STEP;
         rau_pkg::ST_OUT: if (status.out_free) cmd.op = rau_pkg::OP_OUT_LOAD;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/rau_datapath.sv
// Datapath: operand registers, shared 32x32 multiplier, binary GCD unit,
// two-lane restoring divider and the output register. Depends on rau_pkg.
`default_nettype none
module rau_datapath #(
   parameter int WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rau_pkg::cmd_type   cmd,
   output rau_pkg::status_type     status,
   input  wire logic [127:0]       req_tdata,
   input  wire logic [2:0]         req_tuser,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [71:0]             rsp_tdata
);

   localparam logic [63:0] LIM = 64'(1) << (WIDTH - 1);

   // operands
   logic [2:0]  action_ff, action_in;
   logic        an_neg_ff, an_neg_in, bn_neg_ff, bn_neg_in, bz_ff, bz_in;
   logic [31:0] an_mag_ff, an_mag_in, bn_mag_ff, bn_mag_in;
   logic [30:0] ad_ff, ad_in, bd_ff, bd_in, fa_ff, fa_in, fb_ff, fb_in;
   // gcd / divider
   logic [63:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [5:0]  k_ff, k_in;
   logic [63:0] r0_ff, r0_in, r1_ff, r1_in, q0_ff, q0_in, q1_ff, q1_in;
   logic [6:0]  cnt_ff, cnt_in;
   // fraction under work
   logic [63:0] p_ff, p_in, mag_ff, mag_in, den_ff, den_in;
   logic [64:0] ta_ff, ta_in;
   logic        neg_ff, neg_in;
   // result and output stage
   logic [31:0] res_num_ff, res_num_in;
   logic [30:0] res_den_ff, res_den_in;
   logic        less_ff, less_in, equal_ff, equal_in, ovf_ff, ovf_in, dbz_ff, dbz_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   logic [31:0] ma, mb;
   logic [64:0] p_sgn, sum, rp0, rp1;
   logic        ge0, ge1;
   logic [63:0] fm, fd;
   logic        fneg;
   logic [30:0] ld_ad, ld_bd;

   function automatic logic [64:0] with_sign(input logic [63:0] m, input logic n);
      with_sign = n ? (65'd0 - {1'b0, m}) : {1'b0, m};
   endfunction

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.mul)
         rau_pkg::MUL_AN_FA: begin ma = an_mag_ff;         mb = {1'b0, fa_ff}; end
         rau_pkg::MUL_BN_FB: begin ma = bn_mag_ff;         mb = {1'b0, fb_ff}; end
         rau_pkg::MUL_AD_FA: begin ma = {1'b0, ad_ff};     mb = {1'b0, fa_ff}; end
         rau_pkg::MUL_AN_BN: begin ma = an_mag_ff;         mb = bn_mag_ff;     end
         rau_pkg::MUL_AD_BD: begin ma = {1'b0, ad_ff};     mb = {1'b0, bd_ff}; end
         rau_pkg::MUL_AN_BD: begin ma = an_mag_ff;         mb = {1'b0, bd_ff}; end
         rau_pkg::MUL_BN_AD: begin ma = bn_mag_ff;         mb = {1'b0, ad_ff}; end
         default: ;
      endcase
   end

   always_comb begin
      p_sgn = with_sign(p_ff, bn_neg_ff);
      sum   = (action_ff == rau_pkg::ACT_SUB) ? ta_ff - p_sgn : ta_ff + p_sgn;
      rp0   = {r0_ff, q0_ff[63]};
      rp1   = {r1_ff, q1_ff[63]};
      ge0   = rp0 >= {1'b0, g_ff};
      ge1   = rp1 >= {1'b0, g_ff};
      fm    = q0_ff;
      fneg  = neg_ff && (q0_ff != 64'd0);
      fd    = (q0_ff == 64'd0) ? 64'd1 : q1_ff;
      ld_ad = (req_tdata[62:32] == 31'd0) ? 31'd1 : req_tdata[62:32];
      ld_bd = (req_tdata[125:95] == 31'd0) ? 31'd1 : req_tdata[125:95];
   end

   always_comb begin
      action_in = action_ff;  an_neg_in = an_neg_ff;  bn_neg_in = bn_neg_ff;
      bz_in     = bz_ff;      an_mag_in = an_mag_ff;  bn_mag_in = bn_mag_ff;
      ad_in     = ad_ff;      bd_in     = bd_ff;      fa_in     = fa_ff;
      fb_in     = fb_ff;      x_in      = x_ff;       y_in      = y_ff;
      g_in      = g_ff;       k_in      = k_ff;       r0_in     = r0_ff;
      r1_in     = r1_ff;      q0_in     = q0_ff;      q1_in     = q1_ff;
      cnt_in    = cnt_ff;     mag_in    = mag_ff;     den_in    = den_ff;
      ta_in     = ta_ff;      neg_in    = neg_ff;
      res_num_in = res_num_ff; res_den_in = res_den_ff;
      less_in   = less_ff;    equal_in  = equal_ff;   ovf_in    = ovf_ff;
      dbz_in    = dbz_ff;     rsp_data_in = rsp_data_ff;
      p_in      = (cmd.mul != rau_pkg::MUL_NONE) ? 64'(ma) * 64'(mb) : p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (cmd.op)
         rau_pkg::OP_LOAD: begin
            action_in = req_tuser;
            an_neg_in = req_tdata[31];
            an_mag_in = req_tdata[31] ? 32'd0 - req_tdata[31:0] : req_tdata[31:0];
            ad_in     = ld_ad;
            bn_neg_in = req_tdata[94];
            bn_mag_in = req_tdata[94] ? 32'd0 - req_tdata[94:63] : req_tdata[94:63];
            bz_in     = req_tdata[94:63] == 32'd0;
            bd_in     = ld_bd;
         end
         rau_pkg::OP_GCD_DEN: begin
            x_in = {33'd0, ad_ff};
            y_in = {33'd0, bd_ff};
            k_in = '0;
         end
         rau_pkg::OP_GCD_RED: begin
            x_in = mag_ff;
            y_in = den_ff;
            k_in = '0;
         end
         rau_pkg::OP_GCD_STEP: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         rau_pkg::OP_GCD_FIN: g_in = (x_ff | y_ff) << k_ff;
         rau_pkg::OP_DIV_DEN: begin
            q0_in  = {33'd0, bd_ff};
            q1_in  = {33'd0, ad_ff};
            r0_in  = '0;
            r1_in  = '0;
            cnt_in = 7'(rau_pkg::DIV_STEPS);
         end
         rau_pkg::OP_DIV_RED: begin
            q0_in  = mag_ff;
            q1_in  = den_ff;
            r0_in  = '0;
            r1_in  = '0;
            cnt_in = 7'(rau_pkg::DIV_STEPS);
         end
         rau_pkg::OP_DIV_STEP: begin
            r0_in  = ge0 ? 64'(rp0 - {1'b0, g_ff}) : rp0[63:0];
            r1_in  = ge1 ? 64'(rp1 - {1'b0, g_ff}) : rp1[63:0];
            q0_in  = {q0_ff[62:0], ge0};
            q1_in  = {q1_ff[62:0], ge1};
            cnt_in = cnt_ff - 7'd1;
         end
         rau_pkg::OP_DIV_SAVE: begin
            fa_in = q0_ff[30:0];
            fb_in = q1_ff[30:0];
         end
         rau_pkg::OP_ST_TA:  ta_in = with_sign(p_ff, an_neg_ff);
         rau_pkg::OP_ST_SUM: begin
            neg_in = sum[64];
            mag_in = sum[64] ? 64'(65'd0 - sum) : sum[63:0];
         end
         rau_pkg::OP_ST_NUM: begin
            mag_in = p_ff;
            neg_in = an_neg_ff ^ bn_neg_ff;
         end
         rau_pkg::OP_ST_DEN: den_in = p_ff;
         rau_pkg::OP_FIN_RED: begin
            res_num_in = fneg ? 32'd0 - fm[31:0] : fm[31:0];
            res_den_in = fd[30:0];
            ovf_in     = (fneg ? (fm > LIM) : (fm >= LIM)) || (fd >= LIM);
            less_in    = 1'b0;
            equal_in   = 1'b0;
            dbz_in     = 1'b0;
         end
         rau_pkg::OP_FIN_CMP: begin
            res_num_in = '0;
            res_den_in = 31'd1;
            ovf_in     = 1'b0;
            dbz_in     = 1'b0;
            less_in    = $signed(ta_ff) < $signed(p_sgn);
            equal_in   = ta_ff == p_sgn;
         end
         rau_pkg::OP_FIN_CLR: begin
            res_num_in = '0;
            res_den_in = 31'd1;
            ovf_in     = 1'b0;
            less_in    = 1'b0;
            equal_in   = 1'b0;
            dbz_in     = action_ff == rau_pkg::ACT_DIV;
         end
         rau_pkg::OP_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {5'd0, dbz_ff, ovf_ff, equal_ff, less_ff, res_den_ff, res_num_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;  an_neg_ff <= an_neg_in;  bn_neg_ff <= bn_neg_in;
      bz_ff     <= bz_in;      an_mag_ff <= an_mag_in;  bn_mag_ff <= bn_mag_in;
      ad_ff     <= ad_in;      bd_ff     <= bd_in;      fa_ff     <= fa_in;
      fb_ff     <= fb_in;      x_ff      <= x_in;       y_ff      <= y_in;
      g_ff      <= g_in;       k_ff      <= k_in;       r0_ff     <= r0_in;
      r1_ff     <= r1_in;      q0_ff     <= q0_in;      q1_ff     <= q1_in;
      cnt_ff    <= cnt_in;     p_ff      <= p_in;       mag_ff    <= mag_in;
      den_ff    <= den_in;     ta_ff     <= ta_in;      neg_ff    <= neg_in;
      res_num_ff <= res_num_in; res_den_ff <= res_den_in;
      less_ff   <= less_in;    equal_ff  <= equal_in;   ovf_ff    <= ovf_in;
      dbz_ff    <= dbz_in;     rsp_data_ff <= rsp_data_in;
   end

   assign status.action   = action_ff;
   assign status.b_zero   = bz_ff;
   assign status.gcd_done = (x_ff == 64'd0) || (y_ff == 64'd0);
   assign status.div_done = cnt_ff == 7'd0;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide, compare of fractions.
// Compare skips GCD and divider; divide by zero or an unused action goes straight to
// output; multiply/divide reduce the result by GCD and division; add/subtract reach
// a common denominator the same way: one-step-per-cycle 64-bit binary GCD, 64-step
// divider. One item at a time; the next is taken after the result enters the output
// register. Sync active-high reset idles the controller and empties the output stage.
`default_nettype none
module rational_arithmetic_unit #(
   parameter int WIDTH = 32   // overflow limit of the reduced result, 8..32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // req_tdata, lowest bit up: a_num[31:0], a_den[62:32], b_num[94:63],
   // b_den[125:95], zero pad [127:126]
   input  wire logic [127:0] req_tdata,
   // req_tuser: action[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rsp_tdata, lowest bit up: res_num[31:0], res_den[62:32], less[63],
   // equal[64], overflow[65], div_by_zero[66], zero pad [71:67]
   output logic [71:0]       rsp_tdata
);

   rau_pkg::cmd_type    cmd;
   rau_pkg::status_type status;

   // controller walks the per-action sequence
   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // datapath holds operands, multiplier, GCD, divider and the output beat
   rau_datapath #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: rtl/core/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rau_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [71:0]  rsp_tdata
);

   // one beat at a time: input closes right after a take
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second req beat taken back to back");

   // stalled result beat stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // less and equal never together
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[63] && rsp_tdata[64]))
      else $error("less and equal both set");

   // division by zero gives zero over one without overflow
   a_dbz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66] |->
         rsp_tdata[31:0] == 32'd0 && rsp_tdata[62:32] == 31'd1 && !rsp_tdata[65])
      else $error("bad division-by-zero result");

   // without overflow the denominator is never zero
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[65] |-> rsp_tdata[62:32] != 31'd0)
      else $error("zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire
